// ===== design/fvc_pkg.sv =====
// ----------------------------------------------------------------------------
// fvc_pkg
// Shared constants and codes of the formation velocity controller.
// ----------------------------------------------------------------------------
package fvc_pkg;

	localparam int VAL_W  = 32;
	localparam int VEL_W  = 24;
	localparam int CFG_W  = 23;
	localparam int MASK_W = 4;

	localparam logic [1:0] REQ_POS  = 2'd0;
	localparam logic [1:0] REQ_LEAD = 2'd1;
	localparam logic [1:0] REQ_TICK = 2'd2;

	localparam logic [1:0] CFG_OWN   = 2'd0;
	localparam logic [1:0] CFG_MASK  = 2'd1;
	localparam logic [1:0] CFG_SPACE = 2'd2;
	localparam logic [1:0] CFG_LIMIT = 2'd3;

	localparam logic [CFG_W-1:0] RESET_FIVE = 23'd327680;
	localparam logic [31:0]      SQRT3_HALF = 32'd3719550787;

endpackage

// ===== design/formation_velocity_controller.sv =====
// ----------------------------------------------------------------------------
// formation_velocity_controller
// Consensus formation velocity with norm saturation, signed Q16.16 in, signed Q8.16 out.
// ----------------------------------------------------------------------------
// Position and leader-velocity words are taken in the idle state. A tick whose
// norm stays within the limit goes from acceptance to the result word through
// these steps: latch the own position, a sum step for each neighbor slot, form
// magnitudes, bit-serial squaring, one compare and one hand-off. A saturated
// tick adds, after the compare, the digit-by-digit square root, a setup step
// and the three restoring dividers run side by side (start, 61 quotient bits,
// done).
// The request side stalls while a tick is at work and while its result word
// waits behind a stalled one.
module formation_velocity_controller import fvc_pkg::*; #(
	parameter int AGENTS = 4
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    req_valid,
	output logic                    req_stall,
	input  logic [1:0]              req_type,
	input  logic [1:0]              agent,
	input  logic signed [VAL_W-1:0] val_x,
	input  logic signed [VAL_W-1:0] val_y,
	input  logic signed [VAL_W-1:0] val_z,
	output logic                    rsp_valid,
	input  logic                    rsp_stall,
	output logic signed [VEL_W-1:0] vel_x,
	output logic signed [VEL_W-1:0] vel_y,
	output logic signed [VEL_W-1:0] vel_z,
	output logic                    was_limited
);
	localparam int AW = (AGENTS > 1) ? $clog2(AGENTS) : 1;
	localparam int IW = (AW > 2) ? AW : 2;
	localparam int SW = 38;
	localparam int MW = 38;
	localparam int PW = 2 * MW;
	localparam int RW = 39;
	localparam int QW = MW + CFG_W;

	typedef enum logic [3:0] {
		ST_IDLE, ST_OFS, ST_ACC, ST_MAG, ST_SQR, ST_CMP, ST_ROOT, ST_SCALE, ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic signed [CFG_W+1:0] ox;
		logic signed [CFG_W+1:0] oy;
	} ofs_t;

	state_t state_q;

	logic [1:0]       own_q;
	logic [MASK_W-1:0] mask_q;
	logic [CFG_W-1:0] space_q;
	logic [CFG_W-1:0] limit_q;

	logic signed [VAL_W-1:0] px_q [AGENTS];
	logic signed [VAL_W-1:0] py_q [AGENTS];
	logic signed [VAL_W-1:0] pz_q [AGENTS];
	logic signed [VAL_W-1:0] lx_q, ly_q, lz_q;
	logic signed [VAL_W-1:0] ox_q, oy_q, oz_q;

	logic [CFG_W-1:0]     h_q;
	logic [1:0]           i_q;
	logic signed [SW-1:0] sx_q, sy_q, sz_q;
	logic [MW-1:0]        mx_q, my_q, mz_q;
	logic [PW-1:0]        qx_q, qy_q, qz_q;
	logic [5:0]           cnt_q;
	logic [PW+1:0]        s_q;
	logic [RW:0]          rem_q;
	logic [RW-1:0]        root_q;
	logic [RW-1:0]        n_q;
	logic [QW-1:0]        dx_q, dy_q, dz_q;
	logic                 start_q;

	logic signed [VEL_W-1:0] rx_q, ry_q, rz_q;
	logic                    rl_q;
	logic                    rsp_valid_q;
	logic signed [VEL_W-1:0] vx_q, vy_q, vz_q;
	logic                    vl_q;

	logic [55:0]   h_prod;
	logic [AW-1:0] rd_idx;
	logic          own_ok;
	logic          agent_ok;
	logic          nb_on;
	ofs_t          ofs_own;
	ofs_t          ofs_nb;
	logic [MW:0]   ax, ay, az;
	logic [PW:0]   s_sum;
	logic [PW-1:0] lsq;
	logic [RW+2:0] r_try;
	logic [RW+1:0] r_trial;
	logic          r_ge;
	logic [RW+2:0] r_diff;
	logic [QW-1:0] qtx, qty, qtz;
	logic          dv_done, dv_done_y, dv_done_z;
	logic          rsp_free;

	function automatic logic [AW-1:0] to_idx(input logic [1:0] v);
		logic [IW-1:0] w;
		w = IW'(v);
		return w[AW-1:0];
	endfunction

	function automatic ofs_t slot_ofs(input logic [1:0] slot, input logic [CFG_W-1:0] d,
		input logic [CFG_W-1:0] h);
		ofs_t o;
		o.ox = '0;
		o.oy = '0;
		case (slot)
			2'd1: o.oy = $signed({2'b00, d});
			2'd2: begin
				o.ox = $signed({2'b00, h});
				o.oy = -$signed({3'b000, d[CFG_W-1:1]});
			end
			2'd3: begin
				o.ox = -$signed({2'b00, h});
				o.oy = -$signed({3'b000, d[CFG_W-1:1]});
			end
			default: o = '0;
		endcase
		return o;
	endfunction

	function automatic logic [MW-1:0] mag(input logic signed [SW-1:0] v);
		return v[SW-1] ? MW'(-v) : MW'(v);
	endfunction

	function automatic logic [PW-1:0] sq_step(input logic [PW-1:0] p, input logic [MW-1:0] m);
		logic [MW:0] a;
		a = {1'b0, p[PW-1:MW]} + (p[0] ? {1'b0, m} : '0);
		return {a, p[MW-1:1]};
	endfunction

	function automatic logic signed [VEL_W-1:0] apply_sign(input logic [QW-1:0] q,
		input logic neg);
		return neg ? -$signed(q[VEL_W-1:0]) : $signed(q[VEL_W-1:0]);
	endfunction

	assign h_prod   = ({33'd0, space_q} * {24'd0, SQRT3_HALF}) + 56'h80000000;
	assign rd_idx   = (state_q == ST_OFS) ? to_idx(own_q) : to_idx(i_q);
	assign own_ok   = int'(own_q) < AGENTS;
	assign agent_ok = int'(agent) < AGENTS;
	assign nb_on    = mask_q[i_q] && (int'(i_q) < AGENTS);
	assign ofs_own  = slot_ofs(own_q, space_q, h_q);
	assign ofs_nb   = slot_ofs(i_q, space_q, h_q);

	assign ax    = {1'b0, mx_q};
	assign ay    = {1'b0, my_q};
	assign az    = {1'b0, mz_q};
	assign s_sum = {1'b0, qx_q} + {1'b0, qy_q} + {1'b0, qz_q};
	assign lsq   = PW'({23'd0, limit_q} * {23'd0, limit_q});

	assign r_try   = {rem_q, s_q[PW+1:PW]};
	assign r_trial = {root_q, 2'b01};
	assign r_ge    = r_try >= {1'b0, r_trial};
	assign r_diff  = r_try - {1'b0, r_trial};

	assign rsp_free = !rsp_valid_q || !rsp_stall;

	fvc_divider #(.DW(QW), .NW(RW)) u_div_x (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (dx_q),
		.divisor  (n_q),
		.quotient (qtx),
		.done     (dv_done)
	);

	fvc_divider #(.DW(QW), .NW(RW)) u_div_y (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (dy_q),
		.divisor  (n_q),
		.quotient (qty),
		.done     (dv_done_y)
	);

	fvc_divider #(.DW(QW), .NW(RW)) u_div_z (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (dz_q),
		.divisor  (n_q),
		.quotient (qtz),
		.done     (dv_done_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			own_q   <= '0;
			mask_q  <= 4'd1;
			space_q <= RESET_FIVE;
			limit_q <= RESET_FIVE;
			for (int k = 0; k < AGENTS; k++) begin
				px_q[k] <= '0;
				py_q[k] <= '0;
				pz_q[k] <= '0;
			end
			lx_q <= '0; ly_q <= '0; lz_q <= '0;
			ox_q <= '0; oy_q <= '0; oz_q <= '0;
			h_q <= '0;
			i_q <= '0;
			sx_q <= '0; sy_q <= '0; sz_q <= '0;
			mx_q <= '0; my_q <= '0; mz_q <= '0;
			qx_q <= '0; qy_q <= '0; qz_q <= '0;
			cnt_q  <= '0;
			s_q    <= '0;
			rem_q  <= '0;
			root_q <= '0;
			n_q    <= '0;
			dx_q <= '0; dy_q <= '0; dz_q <= '0;
			start_q <= 1'b0;
			rx_q <= '0; ry_q <= '0; rz_q <= '0;
			rl_q <= 1'b0;
			rsp_valid_q <= 1'b0;
			vx_q <= '0; vy_q <= '0; vz_q <= '0;
			vl_q <= 1'b0;
		end else begin
			start_q <= 1'b0;
			if (state_q == ST_DONE && rsp_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_OWN:   own_q   <= cfg_data[1:0];
					CFG_MASK:  mask_q  <= cfg_data[MASK_W-1:0];
					CFG_SPACE: space_q <= cfg_data;
					CFG_LIMIT: limit_q <= cfg_data;
					default:   own_q   <= own_q;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (req_valid) begin
						case (req_type)
							REQ_POS: begin
								if (agent_ok) begin
									px_q[to_idx(agent)] <= val_x;
									py_q[to_idx(agent)] <= val_y;
									pz_q[to_idx(agent)] <= val_z;
								end
							end
							REQ_LEAD: begin
								lx_q <= val_x;
								ly_q <= val_y;
								lz_q <= val_z;
							end
							REQ_TICK: state_q <= ST_OFS;
							default:  state_q <= ST_IDLE;
						endcase
					end
				end
				ST_OFS: begin
					h_q  <= h_prod[54:32];
					ox_q <= own_ok ? px_q[rd_idx] : '0;
					oy_q <= own_ok ? py_q[rd_idx] : '0;
					oz_q <= own_ok ? pz_q[rd_idx] : '0;
					sx_q <= SW'(lx_q);
					sy_q <= SW'(ly_q);
					sz_q <= SW'(lz_q);
					i_q  <= '0;
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					if (nb_on) begin
						sx_q <= sx_q + SW'(px_q[rd_idx]) - SW'(ox_q)
							+ SW'(ofs_own.ox) - SW'(ofs_nb.ox);
						sy_q <= sy_q + SW'(py_q[rd_idx]) - SW'(oy_q)
							+ SW'(ofs_own.oy) - SW'(ofs_nb.oy);
						sz_q <= sz_q + SW'(pz_q[rd_idx]) - SW'(oz_q);
					end
					i_q <= i_q + 2'd1;
					if (i_q == 2'd3) begin
						state_q <= ST_MAG;
					end
				end
				ST_MAG: begin
					mx_q <= mag(sx_q);
					my_q <= mag(sy_q);
					mz_q <= mag(sz_q);
					qx_q <= {{MW{1'b0}}, mag(sx_q)};
					qy_q <= {{MW{1'b0}}, mag(sy_q)};
					qz_q <= {{MW{1'b0}}, mag(sz_q)};
					cnt_q <= 6'(MW);
					state_q <= ST_SQR;
				end
				ST_SQR: begin
					qx_q <= sq_step(qx_q, ax[MW-1:0]);
					qy_q <= sq_step(qy_q, ay[MW-1:0]);
					qz_q <= sq_step(qz_q, az[MW-1:0]);
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= ST_CMP;
					end
				end
				ST_CMP: begin
					s_q    <= {1'b0, s_sum};
					rem_q  <= '0;
					root_q <= '0;
					cnt_q  <= 6'(RW);
					if (s_sum > {1'b0, lsq}) begin
						state_q <= ST_ROOT;
					end else begin
						rx_q <= sx_q[VEL_W-1:0];
						ry_q <= sy_q[VEL_W-1:0];
						rz_q <= sz_q[VEL_W-1:0];
						rl_q <= 1'b0;
						state_q <= ST_DONE;
					end
				end
				ST_ROOT: begin
					rem_q  <= r_ge ? r_diff[RW:0] : r_try[RW:0];
					root_q <= {root_q[RW-2:0], r_ge};
					s_q    <= {s_q[PW-1:0], 2'b00};
					cnt_q  <= cnt_q - 6'd1;
					if (cnt_q == 6'd1) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: begin
					n_q  <= root_q + RW'(rem_q != '0);
					dx_q <= {23'd0, mx_q} * {38'd0, limit_q};
					dy_q <= {23'd0, my_q} * {38'd0, limit_q};
					dz_q <= {23'd0, mz_q} * {38'd0, limit_q};
					start_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (dv_done && dv_done_y && dv_done_z) begin
						rx_q <= apply_sign(qtx, sx_q[SW-1]);
						ry_q <= apply_sign(qty, sy_q[SW-1]);
						rz_q <= apply_sign(qtz, sz_q[SW-1]);
						rl_q <= 1'b1;
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (rsp_free) begin
						vx_q <= rx_q;
						vy_q <= ry_q;
						vz_q <= rz_q;
						vl_q <= rl_q;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall   = state_q != ST_IDLE;
	assign rsp_valid   = rsp_valid_q;
	assign vel_x       = vx_q;
	assign vel_y       = vy_q;
	assign vel_z       = vz_q;
	assign was_limited = vl_q;

endmodule

// ===== design/fvc_divider.sv =====
// ----------------------------------------------------------------------------
// fvc_divider
// Restoring divider, one quotient bit per cycle, DW quotient bits per word.
// ----------------------------------------------------------------------------
module fvc_divider import fvc_pkg::*; #(
	parameter int DW = 61,
	parameter int NW = 39
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [NW-1:0] divisor,
	output logic [DW-1:0] quotient,
	output logic          done
);
	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [NW-1:0] rem_q;
	logic [NW-1:0] den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [NW:0]   trial;
	logic [NW:0]   diff;
	logic          ge;

	assign trial = {rem_q, quo_q[DW-1]};
	assign ge    = trial >= {1'b0, den_q};
	assign diff  = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q  <= '0;
			rem_q  <= '0;
			den_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				quo_q  <= dividend;
				rem_q  <= '0;
				den_q  <= divisor;
				cnt_q  <= CW'(DW);
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[NW-1:0] : trial[NW-1:0];
				quo_q <= {quo_q[DW-2:0], ge};
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// ===== design/fvc_checker.sv =====
// ----------------------------------------------------------------------------
// fvc_checker
// Port-level checks of the formation velocity controller, bound to the top.
// ----------------------------------------------------------------------------
module fvc_checker import fvc_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    req_valid,
	input logic                    req_stall,
	input logic [1:0]              req_type,
	input logic                    rsp_valid,
	input logic                    rsp_stall,
	input logic signed [VEL_W-1:0] vel_x,
	input logic signed [VEL_W-1:0] vel_y,
	input logic signed [VEL_W-1:0] vel_z,
	input logic                    was_limited
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(vel_x) && $stable(vel_y)
			&& $stable(vel_z) && $stable(was_limited))
		else $error("stalled result word changed");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type == REQ_TICK |=> req_stall)
		else $error("tick word did not occupy the block");

	a_update_free: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type != REQ_TICK |=> !req_stall)
		else $error("update word held the request side");

	a_no_early_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req_type == REQ_TICK && !rsp_valid |=> !rsp_valid)
		else $error("result word appeared one cycle after tick");

endmodule

bind formation_velocity_controller fvc_checker u_fvc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req_valid),
	.req_stall   (req_stall),
	.req_type    (req_type),
	.rsp_valid   (rsp_valid),
	.rsp_stall   (rsp_stall),
	.vel_x       (vel_x),
	.vel_y       (vel_y),
	.vel_z       (vel_z),
	.was_limited (was_limited)
);
